// File: hw/rtl/osd_palette_allocator_defines.svh
// ----------------------------------------------------------------------------
// OSD palette allocator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef OSD_PALETTE_ALLOCATOR_DEFINES_SVH
`define OSD_PALETTE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define OSD_PAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OSD_PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OSD_PAL_ASSERT(lbl, prop, msg)
`define OSD_PAL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/osd_pal_pkg.sv
// ----------------------------------------------------------------------------
// OSD palette allocator package
// Shared constants, control structures and gradient lane arithmetic.
// ----------------------------------------------------------------------------
package osd_pal_pkg;

	localparam int TEXT_ENTRIES = 11;
	localparam int EDGE_OFFSET  = 6;
	localparam int FORE_OFFSET  = 10;
	localparam int STEP_W       = 4;
	localparam int LANES        = 4;
	localparam int OPA_LANE     = 3;

	// Number of blend steps in the background-to-border and border-to-foreground runs.
	localparam logic [3:0] BLEND_A_LEN = 4'd5;
	localparam logic [3:0] BLEND_B_LEN = 4'd4;

	// Reciprocal of five scaled by 1024, exact for magnitudes up to 255.
	localparam logic [15:0] RECIP_FIVE = 16'd205;

	typedef struct packed {
		logic [7:0] from;
		logic       neg;
		logic [7:0] dq;
		logic [2:0] dr;
	} lane_t;

	typedef struct packed {
		logic load;
		logic advance;
	} grad_ctl_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              last;
	} grad_sts_t;

	// Splits |to - from| into quotient and remainder by the run length.
	function automatic lane_t lane_setup(input logic [7:0] from, input logic [7:0] to,
	                                     input logic by_five);
		logic [8:0]  diff;
		logic [7:0]  mag;
		logic [15:0] prod;
		logic [7:0]  q;
		logic [7:0]  r;
		lane_t       res;
		diff = {1'b0, to} - {1'b0, from};
		mag  = diff[8] ? (~diff[7:0] + 8'd1) : diff[7:0];
		prod = {8'd0, mag} * RECIP_FIVE;
		if (by_five) begin
			q = {2'b00, prod[15:10]};
			r = mag - ({q[5:0], 2'b00} + q);
		end else begin
			q = {2'b00, mag[7:2]};
			r = {6'd0, mag[1:0]};
		end
		res.from = from;
		res.neg  = diff[8];
		res.dq   = q;
		res.dr   = r[2:0];
		return res;
	endfunction

	// Truncating blend for colour bytes, flooring blend for transparency.
	function automatic logic [7:0] lane_value(input lane_t l, input logic [7:0] acc,
	                                          input logic [2:0] rem, input logic floor_mode);
		logic [7:0] v;
		if (l.neg) begin
			v = l.from - acc;
			if (floor_mode && (rem != 3'd0)) begin
				v = v - 8'd1;
			end
		end else begin
			v = l.from + acc;
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/osd_pal_ram.sv
// ----------------------------------------------------------------------------
// OSD palette RAM
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module osd_pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hw/rtl/osd_pal_grad.sv
// ----------------------------------------------------------------------------
// OSD palette text gradient generator
// Produces the eleven text palette entries, one per cycle while advance is high,
// by stepping per-lane quotient and remainder accumulators instead of dividing.
// ----------------------------------------------------------------------------
module osd_pal_grad import osd_pal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  grad_ctl_t   ctl,
	input  logic [23:0] back_color,
	input  logic [7:0]  back_opacity,
	input  logic [23:0] edge_color,
	input  logic [7:0]  edge_opacity,
	input  logic [23:0] fore_color,
	input  logic [7:0]  fore_opacity,
	output grad_sts_t   sts,
	output logic [23:0] entry_color,
	output logic [7:0]  entry_opacity
);

	lane_t             lane_a_q [LANES];
	lane_t             lane_b_q [LANES];
	logic [7:0]        acc_q    [LANES];
	logic [2:0]        rem_q    [LANES];
	logic [7:0]        back_b   [LANES];
	logic [7:0]        edge_b   [LANES];
	logic [7:0]        fore_b   [LANES];
	logic [7:0]        lane_val [LANES];
	logic [STEP_W-1:0] step_q;
	logic              phase_b;
	logic              restart;
	logic              hold;

	always_comb begin
		for (int i = 0; i < LANES - 1; i++) begin
			back_b[i] = back_color[8*i +: 8];
			edge_b[i] = edge_color[8*i +: 8];
			fore_b[i] = fore_color[8*i +: 8];
		end
		back_b[OPA_LANE] = back_opacity;
		edge_b[OPA_LANE] = edge_opacity;
		fore_b[OPA_LANE] = fore_opacity;
	end

	// Entries 0 and 1 both carry the background, so the first step does not advance.
	assign phase_b = step_q >= STEP_W'(EDGE_OFFSET);
	assign restart = step_q == STEP_W'(EDGE_OFFSET - 1);
	assign hold    = step_q == '0;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lane_t      cur;
		logic [3:0] nlen;
		logic [3:0] rsum;
		logic       wrap;

		always_comb begin
			cur  = phase_b ? lane_b_q[g] : lane_a_q[g];
			nlen = phase_b ? BLEND_B_LEN : BLEND_A_LEN;
			rsum = {1'b0, rem_q[g]} + {1'b0, cur.dr};
			wrap = rsum >= nlen;
		end

		always_ff @(posedge clk) begin
			if (ctl.load) begin
				lane_a_q[g] <= lane_setup(back_b[g], edge_b[g], 1'b1);
				lane_b_q[g] <= lane_setup(edge_b[g], fore_b[g], 1'b0);
				acc_q[g]    <= '0;
				rem_q[g]    <= '0;
			end else if (ctl.advance && !hold) begin
				if (restart) begin
					acc_q[g] <= '0;
					rem_q[g] <= '0;
				end else if (wrap) begin
					acc_q[g] <= acc_q[g] + cur.dq + 8'd1;
					rem_q[g] <= 3'(rsum - nlen);
				end else begin
					acc_q[g] <= acc_q[g] + cur.dq;
					rem_q[g] <= rsum[2:0];
				end
			end
		end

		assign lane_val[g] = lane_value(cur, acc_q[g], rem_q[g], 1'(g == OPA_LANE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctl.load) begin
			step_q <= '0;
		end else if (ctl.advance && !sts.last) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign sts.step      = step_q;
	assign sts.last      = step_q == STEP_W'(FORE_OFFSET);
	assign entry_color   = {lane_val[2], lane_val[1], lane_val[0]};
	assign entry_opacity = lane_val[OPA_LANE];

endmodule

// File: hw/rtl/osd_palette_allocator.sv
// ----------------------------------------------------------------------------
// OSD palette allocator
// Keeps a palette of Y/Cr/Cb colours with transparency in one RAM, looks up
// or appends single entries and reserves eleven-entry text gradients.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one request per transfer:
// opcode 0 looks up color_value/opacity and appends it when absent, opcode 1
// writes a text gradient at the fill point. The output channel
// (out_valid/out_ready) returns slot_index, palette_full and already_present,
// one result per request, in order.
// Requests are handled one at a time. A lookup reads one palette entry per
// cycle through the single RAM port; a gradient writes one entry per cycle.
// A gradient request that does not fit answers with palette_full set.
// The result register lets the next request be taken while a result still
// waits; if the receiver stalls, the following result is held until the
// register frees. Reset empties the palette by clearing the fill count; the
// RAM itself is not cleared and is only read below the fill count.
// ----------------------------------------------------------------------------
`include "osd_palette_allocator_defines.svh"

module osd_palette_allocator import osd_pal_pkg::*; #(
	parameter int PALETTE_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [23:0] color_value,
	input  logic [7:0]  opacity,
	input  logic [23:0] back_color,
	input  logic [7:0]  back_opacity,
	input  logic [23:0] edge_color,
	input  logic [7:0]  edge_opacity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  slot_index,
	output logic        palette_full,
	output logic        already_present
);

	localparam int AW = $clog2(PALETTE_SIZE);
	localparam int CW = $clog2(PALETTE_SIZE + 1);
	localparam int SW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] SIZE_C     = CW'(PALETTE_SIZE);
	localparam logic [CW-1:0] TEXT_LIMIT = CW'(PALETTE_SIZE - TEXT_ENTRIES);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_GRAD   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] ridx_q;
	logic          rvalid_s1;
	logic [AW-1:0] cidx_s1;
	logic [23:0]   col_q;
	logic [7:0]    opa_q;
	logic [CW-1:0] res_slot_q;
	logic          res_full_q;
	logic          res_found_q;
	logic [SW-1:0] res_wide;

	logic          in_acc;
	logic          issue;
	logic          hit;
	logic          miss;
	logic          append;
	logic          grad_wr;
	logic          out_load;
	logic [CW-1:0] wr_index;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	grad_ctl_t     grad_ctl;
	grad_sts_t     grad_sts;
	logic [23:0]   entry_color;
	logic [7:0]    entry_opacity;

	assign in_ready = state_q == ST_IDLE;
	assign in_acc   = in_valid && in_ready;

	// Lookup pipeline: address issued one cycle, compared the next.
	assign hit     = rvalid_s1 && (ram_rdata == {col_q, opa_q});
	assign issue   = (state_q == ST_SEARCH) && (ridx_q < fill_q) && !hit;
	assign miss    = (state_q == ST_SEARCH) && !hit && !rvalid_s1 && (ridx_q >= fill_q);
	assign append  = miss && (fill_q != SIZE_C);
	assign grad_wr = state_q == ST_GRAD;

	assign wr_index  = grad_wr ? (fill_q + CW'(grad_sts.step)) : fill_q;
	assign ram_we    = append || grad_wr;
	assign ram_addr  = ram_we ? wr_index[AW-1:0] : ridx_q[AW-1:0];
	assign ram_wdata = grad_wr ? {entry_color, entry_opacity} : {col_q, opa_q};

	assign grad_ctl.load    = in_acc && opcode;
	assign grad_ctl.advance = grad_wr;

	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);
	assign res_wide = SW'(res_slot_q);

	osd_pal_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (issue),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	osd_pal_grad u_grad (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (grad_ctl),
		.back_color   (back_color),
		.back_opacity (back_opacity),
		.edge_color   (edge_color),
		.edge_opacity (edge_opacity),
		.fore_color   (color_value),
		.fore_opacity (opacity),
		.sts          (grad_sts),
		.entry_color  (entry_color),
		.entry_opacity(entry_opacity)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= color_value;
			opa_q <= opacity;
		end
		cidx_s1 <= ridx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			fill_q          <= '0;
			ridx_q          <= '0;
			rvalid_s1       <= 1'b0;
			res_slot_q      <= '0;
			res_full_q      <= 1'b0;
			res_found_q     <= 1'b0;
			out_valid       <= 1'b0;
			slot_index      <= '0;
			palette_full    <= 1'b0;
			already_present <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ridx_q <= '0;
						if (!opcode) begin
							state_q <= ST_SEARCH;
						end else if (fill_q > TEXT_LIMIT) begin
							res_slot_q  <= '0;
							res_full_q  <= 1'b1;
							res_found_q <= 1'b0;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_GRAD;
						end
					end
				end
				ST_SEARCH: begin
					ridx_q <= ridx_q + CW'(issue);
					if (hit) begin
						res_slot_q  <= CW'(cidx_s1);
						res_full_q  <= 1'b0;
						res_found_q <= 1'b1;
						state_q     <= ST_DONE;
					end else if (miss) begin
						res_found_q <= 1'b0;
						if (append) begin
							res_slot_q <= fill_q;
							res_full_q <= 1'b0;
							fill_q     <= fill_q + CW'(1);
						end else begin
							res_slot_q <= '0;
							res_full_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_GRAD: begin
					if (grad_sts.last) begin
						res_slot_q  <= fill_q;
						res_full_q  <= 1'b0;
						res_found_q <= 1'b0;
						fill_q      <= fill_q + CW'(TEXT_ENTRIES);
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid       <= 1'b1;
				slot_index      <= res_wide[7:0];
				palette_full    <= res_full_q;
				already_present <= res_found_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	`OSD_PAL_ASSERT(a_write_in_range, ram_we |-> (wr_index < SIZE_C), "palette write beyond the last entry")
	`OSD_PAL_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE, "accepted transfer left the block idle")
	`OSD_PAL_ASSERT(a_hit_below_fill, hit |-> (CW'(cidx_s1) < fill_q), "match reported on an unfilled entry")
	`OSD_PAL_ASSERT(a_fill_moves_on_write, (fill_q != $past(fill_q)) |-> $past(ram_we), "fill count moved without a palette write")

endmodule

// File: verif/osd_palette_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD palette allocator testbench
// Drives lookups, appends and text-gradient allocations through the request
// channel with random idle bursts on both sides. A palette tracker checks
// every returned slot, full flag and hit flag against its own palette copy.
// ----------------------------------------------------------------------------
import osd_pal_pkg::*;

localparam int PAL_DEPTH = 256;

typedef enum logic {
	OP_FIND_ADD     = 1'b0,
	OP_TEXT_PALETTE = 1'b1
} palette_op_t;

typedef struct {
	palette_op_t op;
	logic [23:0] color;
	logic [7:0]  opa;
	logic [23:0] back;
	logic [7:0]  back_opa;
	logic [23:0] border;
	logic [7:0]  border_opa;
} palette_req_t;

typedef struct {
	logic [7:0] slot;
	logic       full;
	logic       present;
} slot_answer_t;

class palette_scoreboard;
	logic [23:0]  color_mem [PAL_DEPTH];
	logic [7:0]   opa_mem [PAL_DEPTH];
	int           fill = 0;
	int           errors = 0;
	slot_answer_t awaited [$];

	// Colour bytes truncate towards zero, transparency rounds towards minus infinity.
	function void blend_run(int lo, int hi, logic [23:0] fc, logic [7:0] ft,
	                        logic [23:0] tc, logic [7:0] tt);
		int n;
		int f;
		int d;
		int v;
		int num;
		logic [23:0] packed_col;
		n = hi - lo;
		for (int k = 0; k < n; k++) begin
			for (int s = 0; s < 24; s += 8) begin
				f = fc[s +: 8];
				d = tc[s +: 8];
				d = d - f;
				v = f + (k * d) / n;
				packed_col[s +: 8] = v[7:0];
			end
			f = ft;
			d = tt;
			num = k * (d - f);
			if (num >= 0) begin
				v = f + num / n;
			end else begin
				v = f - ((-num + n - 1) / n);
			end
			color_mem[lo + k] = packed_col;
			opa_mem[lo + k] = v[7:0];
		end
		color_mem[hi] = tc;
		opa_mem[hi] = tt;
	endfunction

	function void note_request(palette_req_t r);
		slot_answer_t a;
		int base;
		a.slot = 8'd0;
		a.full = 1'b0;
		a.present = 1'b0;
		if (r.op == OP_FIND_ADD) begin
			for (int i = 0; i < fill; i++) begin
				if (!a.present && color_mem[i] == r.color && opa_mem[i] == r.opa) begin
					a.slot = i[7:0];
					a.present = 1'b1;
				end
			end
			if (!a.present) begin
				if (fill >= PAL_DEPTH) begin
					a.full = 1'b1;
				end else begin
					a.slot = fill[7:0];
					color_mem[fill] = r.color;
					opa_mem[fill] = r.opa;
					fill++;
				end
			end
		end else begin
			if (fill + TEXT_ENTRIES > PAL_DEPTH) begin
				a.full = 1'b1;
			end else begin
				base = fill;
				color_mem[base] = r.back;
				opa_mem[base] = r.back_opa;
				blend_run(base + 1, base + EDGE_OFFSET, r.back, r.back_opa,
				          r.border, r.border_opa);
				blend_run(base + EDGE_OFFSET, base + FORE_OFFSET, r.border, r.border_opa,
				          r.color, r.opa);
				fill += TEXT_ENTRIES;
				a.slot = base[7:0];
			end
		end
		awaited.push_back(a);
	endfunction

	function void check_result(logic [7:0] slot, logic full, logic present);
		slot_answer_t a;
		if (awaited.size() == 0) begin
			$error("result with nothing outstanding: slot_index %0d", slot);
			errors++;
		end else begin
			a = awaited.pop_front();
			if (slot !== a.slot) begin
				$error("slot_index expected %0d actual %0d", a.slot, slot);
				errors++;
			end
			if (full !== a.full) begin
				$error("palette_full expected %0d actual %0d", a.full, full);
				errors++;
			end
			if (present !== a.present) begin
				$error("already_present expected %0d actual %0d", a.present, present);
				errors++;
			end
		end
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction
endclass

module osd_palette_allocator_test;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_ITEMS   = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = 1'b0;
	logic [23:0] color_value = 24'd0;
	logic [7:0]  opacity = 8'd0;
	logic [23:0] back_color = 24'd0;
	logic [7:0]  back_opacity = 8'd0;
	logic [23:0] edge_color = 24'd0;
	logic [7:0]  edge_opacity = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  slot_index;
	logic        palette_full;
	logic        already_present;

	palette_scoreboard book;
	int idle_pct = 30;
	bit calm = 1'b0;

	osd_palette_allocator #(
		.PALETTE_SIZE(PAL_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.color_value(color_value),
		.opacity(opacity),
		.back_color(back_color),
		.back_opacity(back_opacity),
		.edge_color(edge_color),
		.edge_opacity(edge_opacity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_index(slot_index),
		.palette_full(palette_full),
		.already_present(already_present)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [23:0] pick_color();
		case ($urandom_range(0, 7))
			0: pick_color = 24'h000000;
			1: pick_color = 24'hffffff;
			default: pick_color = 24'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] pick_opa();
		case ($urandom_range(0, 7))
			0: pick_opa = 8'h00;
			1: pick_opa = 8'hff;
			default: pick_opa = 8'($urandom());
		endcase
	endfunction

	function automatic palette_req_t make_req(palette_op_t op, logic [23:0] col,
	                                          logic [7:0] opa, logic [23:0] bc,
	                                          logic [7:0] bo, logic [23:0] ec,
	                                          logic [7:0] eo);
		palette_req_t r;
		r.op = op;
		r.color = col;
		r.opa = opa;
		r.back = bc;
		r.back_opa = bo;
		r.border = ec;
		r.border_opa = eo;
		return r;
	endfunction

	// Lookup of a pair already in the palette, so the search runs deep.
	function automatic palette_req_t stored_lookup();
		int idx;
		idx = $urandom_range(0, book.fill - 1);
		return make_req(OP_FIND_ADD, book.color_mem[idx], book.opa_mem[idx],
		                pick_color(), pick_opa(), pick_color(), pick_opa());
	endfunction

	function automatic palette_req_t random_req();
		palette_req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r = make_req(OP_FIND_ADD, pick_color(), pick_opa(), pick_color(), pick_opa(),
		             pick_color(), pick_opa());
		if (roll < 4) begin
			r.op = OP_TEXT_PALETTE;
		end else if (roll < 10 || book.fill == 0) begin
			if (book.fill != 0 && roll < 7) begin
				// A stored colour with one transparency bit flipped must not match.
				r = stored_lookup();
				r.opa[$urandom_range(0, 7)] ^= 1'b1;
			end
		end else begin
			r = stored_lookup();
		end
		return r;
	endfunction

	// Holds the request until its transfer, then at random drops in_valid for a gap.
	task automatic push_request(palette_req_t r);
		opcode <= r.op;
		color_value <= r.color;
		opacity <= r.opa;
		back_color <= r.back;
		back_opacity <= r.back_opa;
		edge_color <= r.border;
		edge_opacity <= r.border_opa;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		book.note_request(r);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				book.check_result(slot_index, palette_full, already_present);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 99) < idle_pct / 3) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		palette_req_t dir [$];
		book = new;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty palette, then repeats and pairs that differ only in one field.
		dir.push_back(make_req(OP_FIND_ADD, 24'h000000, 8'h00, 24'hffffff, 8'hff,
		                       24'hffffff, 8'hff));
		dir.push_back(make_req(OP_FIND_ADD, 24'h000000, 8'h00, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		dir.push_back(make_req(OP_FIND_ADD, 24'hffffff, 8'hff, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		dir.push_back(make_req(OP_FIND_ADD, 24'hffffff, 8'h00, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		dir.push_back(make_req(OP_FIND_ADD, 24'h000000, 8'hff, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		dir.push_back(make_req(OP_FIND_ADD, 24'hffffff, 8'hff, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		// Gradients with full-scale rising and falling runs.
		dir.push_back(make_req(OP_TEXT_PALETTE, 24'h000000, 8'h00, 24'h000000, 8'h00,
		                       24'hffffff, 8'hff));
		dir.push_back(make_req(OP_TEXT_PALETTE, 24'hffffff, 8'hff, 24'hffffff, 8'hff,
		                       24'h000000, 8'h00));
		// Mixed signs per lane and odd remainders on the transparency.
		dir.push_back(make_req(OP_TEXT_PALETTE, 24'h7f8000, 8'h01, 24'h10f080, 8'h03,
		                       24'hf01081, 8'hfe));
		// A flat gradient fills eleven identical entries.
		dir.push_back(make_req(OP_TEXT_PALETTE, 24'h123456, 8'haa, 24'h123456, 8'haa,
		                       24'h123456, 8'haa));
		dir.push_back(make_req(OP_FIND_ADD, 24'h123456, 8'haa, 24'h000000, 8'h00,
		                       24'h000000, 8'h00));
		foreach (dir[i]) push_request(dir[i]);
		// Lookups of pairs already stored in the palette.
		repeat (8) push_request(stored_lookup());
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 25;
					default: idle_pct = 60;
				endcase
			end
			if (n == RANDOM_ITEMS / 2) begin
				drain_results();
			end
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			push_request(random_req());
		end
		drain_results();
		repeat (300) @(posedge clk);
		if (book.errors == 0 && book.outstanding() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
